// ===== rtl/vfdz_pkg.sv =====
// Shared types, constants and the control program of the viewport follow unit.
// Depends on nothing; used by viewport_follow_dead_zone_unit and vfdz_checker.
package vfdz_pkg;

    // Field widths
    localparam int COORD_W   = 24;   // signed Q15.8 input coordinate
    localparam int SIZE_W    = 24;   // unsigned Q16.8 size
    localparam int POS_W     = 23;   // viewport edge
    localparam int DIR_W     = 2;    // signed direction
    localparam int OFF_W     = 25;   // signed Q16.8 centre offset
    localparam int FRAC_W    = 17;   // unsigned Q1.16 fraction
    localparam int RATIO_FRAC_BITS = 16;

    // Datapath widths: every intermediate fits in WORK_W signed bits
    localparam int WORK_W    = 28;
    localparam int MUL_B_W   = FRAC_W + 1;
    localparam int PROD_W    = WORK_W + MUL_B_W;

    localparam logic [FRAC_W-1:0] ONE_FRAC = FRAC_W'(1 << RATIO_FRAC_BITS);
    localparam logic [FRAC_W-1:0] HALF_FRAC = FRAC_W'(1 << (RATIO_FRAC_BITS - 1));
    localparam logic [POS_W-1:0]  POS_MAX = '1;

    // Stream payload layout
    localparam int IN_BITS    = 2 * COORD_W + DIR_W;
    localparam int IN_DATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS   = 2 * POS_W + DIR_W + OFF_W;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;
    localparam logic [CFG_IDX_W-1:0] CFG_VIEW_SIZE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WORLD_SIZE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FOLLOW_RATE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_H_ANCHORS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_H_TRIGGERS  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_V_ANCHOR    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_DEAD_ZONES  = 3'd6;

    // Direction codes
    localparam logic [DIR_W-1:0] DIR_NONE  = 2'b00;
    localparam logic [DIR_W-1:0] DIR_RIGHT = 2'b01;
    localparam logic [DIR_W-1:0] DIR_NEG2  = 2'b10;
    localparam logic [DIR_W-1:0] DIR_LEFT  = 2'b11;

    // Sequencer
    localparam int PC_W = 4;

    typedef enum logic [3:0] {
        OP_RELEASE,     // drop armed direction on reversal
        OP_MUL_RT,      // prod = vw*right_trigger, wx = view_left
        OP_ARM_R,       // arm right
        OP_MUL_LT,      // prod = vw*left_trigger
        OP_ARM_L,       // arm left
        OP_MUL_ANCHOR,  // prod = vw*anchor of armed side
        OP_DIFF,        // d = desired - wx
        OP_MUL_RATE,    // prod = d*rate
        OP_ADD_X,       // wx += prod
        OP_OFFSET,      // centre offset, prod = vh*vertical_anchor
        OP_DEAD_ZONE,   // vertical dead zone
        OP_CLAMP,       // world clamp into state
        OP_DONE,        // hand result to output register
        OP_CENTER       // centered placement
    } op_t;

    typedef enum logic [2:0] {
        COND_NONE,
        COND_ALWAYS,
        COND_CENTERED,
        COND_RELEASED,
        COND_OUT_FULL
    } cond_t;

    typedef struct packed {
        op_t              op;
        cond_t            cond;
        logic [PC_W-1:0]  target;
    } ctrl_word_t;

    localparam logic [PC_W-1:0] STEP_OFFSET = 4'd9;
    localparam logic [PC_W-1:0] STEP_CLAMP  = 4'd11;
    localparam logic [PC_W-1:0] STEP_DONE   = 4'd12;
    localparam logic [PC_W-1:0] STEP_CENTER = 4'd13;

    // Control store
    function automatic ctrl_word_t prog_rom(input logic [PC_W-1:0] pc);
        ctrl_word_t w;
        w = '{op: OP_DONE, cond: COND_NONE, target: '0};
        unique case (pc)
            4'd0:  w = '{op: OP_RELEASE,    cond: COND_CENTERED, target: STEP_CENTER};
            4'd1:  w = '{op: OP_MUL_RT,     cond: COND_NONE,     target: '0};
            4'd2:  w = '{op: OP_ARM_R,      cond: COND_NONE,     target: '0};
            4'd3:  w = '{op: OP_MUL_LT,     cond: COND_NONE,     target: '0};
            4'd4:  w = '{op: OP_ARM_L,      cond: COND_NONE,     target: '0};
            4'd5:  w = '{op: OP_MUL_ANCHOR, cond: COND_RELEASED, target: STEP_OFFSET};
            4'd6:  w = '{op: OP_DIFF,       cond: COND_NONE,     target: '0};
            4'd7:  w = '{op: OP_MUL_RATE,   cond: COND_NONE,     target: '0};
            4'd8:  w = '{op: OP_ADD_X,      cond: COND_NONE,     target: '0};
            4'd9:  w = '{op: OP_OFFSET,     cond: COND_NONE,     target: '0};
            4'd10: w = '{op: OP_DEAD_ZONE,  cond: COND_NONE,     target: '0};
            4'd11: w = '{op: OP_CLAMP,      cond: COND_NONE,     target: '0};
            4'd12: w = '{op: OP_DONE,       cond: COND_OUT_FULL, target: STEP_DONE};
            4'd13: w = '{op: OP_CENTER,     cond: COND_ALWAYS,   target: STEP_CLAMP};
            default: w = '{op: OP_DONE, cond: COND_NONE, target: '0};
        endcase
        return w;
    endfunction

    // Fractions saturate at one
    function automatic logic [FRAC_W-1:0] frac_sat(input logic [FRAC_W-1:0] raw);
        return (raw > ONE_FRAC) ? ONE_FRAC : raw;
    endfunction

endpackage

// ===== rtl/viewport_follow_dead_zone_unit.sv =====
// Top level of the viewport follow unit with horizontal triggers and a vertical dead zone.
// Depends on vfdz_pkg (types, control program, constants).

// Camera follow engine. Each accepted update (s_tuser = mode, s_tdata = target and
// move direction) runs a short microprogram on one shared 28x18 multiplier and one
// adder/compare datapath, one control word per clock unless a full output holds the
// program in its last step. A centered update takes 4 sequencer steps. A platformer
// update takes 13 when a follow direction is armed, and 10 when it stays released,
// because the approach steps are skipped. A new update is accepted only once the
// previous program has finished. The result lands in an output register, so the next
// update is taken while the previous result waits on m_tready; a result that cannot
// leave stalls the program in its last step. Configuration is to be written through
// cfg_we/cfg_index/cfg_data only while the block is idle (the block itself does not
// enforce this) and takes effect on the next update. There is no clearing pass: the
// control, state and configuration registers reset at once; work registers do not.
module viewport_follow_dead_zone_unit
(
    input  logic                                clk,
    input  logic                                rst_n,
    // input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [23:0] target_x, [47:24] target_y, [49:48] move_direction, zero fill above
    input  logic [vfdz_pkg::IN_DATA_W-1:0]      s_tdata,
    // [0] req_type
    input  logic                                s_tuser,
    // result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [22:0] camera_x, [45:23] camera_y, [47:46] follow_direction,
    // [72:48] centre_offset_x, zero fill above
    output logic [vfdz_pkg::OUT_DATA_W-1:0]     m_tdata,
    // configuration writes
    input  logic                                cfg_we,
    input  logic [vfdz_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [vfdz_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int WW = vfdz_pkg::WORK_W;
    localparam int CW = vfdz_pkg::COORD_W;
    localparam int SW = vfdz_pkg::SIZE_W;
    localparam int FW = vfdz_pkg::FRAC_W;
    localparam int PW = vfdz_pkg::POS_W;
    localparam int DW = vfdz_pkg::DIR_W;
    localparam int OW = vfdz_pkg::OFF_W;

    // Configuration registers
    logic [2*SW-1:0] view_size_reg;
    logic [2*SW-1:0] world_size_reg;
    logic [FW-1:0]   follow_rate_reg;
    logic [2*FW-1:0] h_anchors_reg;
    logic [2*FW-1:0] h_triggers_reg;
    logic [FW-1:0]   v_anchor_reg;
    logic [2*SW-1:0] dead_zones_reg;

    // Architectural state
    logic [PW-1:0] view_left_reg, view_left_next;
    logic [PW-1:0] view_top_reg,  view_top_next;
    logic [DW-1:0] dir_reg,       dir_next;

    // Sequencer control
    logic                        busy_reg, busy_next;
    logic [vfdz_pkg::PC_W-1:0]   pc_reg,   pc_next;
    logic                        out_valid_reg, out_valid_next;

    // Latched transaction and work registers
    logic                    type_reg;
    logic signed [CW-1:0]    tx_reg, ty_reg;
    logic [DW-1:0]           md_reg;
    logic signed [WW-1:0]    wx_reg, wx_next;
    logic signed [WW-1:0]    wy_reg, wy_next;
    logic signed [WW-1:0]    d_reg,  d_next;
    logic signed [WW-1:0]    prod_reg, prod_next;
    logic signed [OW-1:0]    off_reg, off_next;
    logic [vfdz_pkg::OUT_BITS-1:0] out_data_reg, out_data_next;

    vfdz_pkg::ctrl_word_t cw;
    logic in_accept;
    logic out_full;
    logic jump;

    // Widened operands
    logic signed [WW-1:0] txw, tyw, vww, vhw, vw_half, vh_half, vlw, vtw;
    logic signed [WW-1:0] upw, downw, lim_x, lim_y;
    logic signed [WW-1:0] rel, base_y, top_lim, bot_lim, off_full;
    logic [FW-1:0] rate_f, ra_f, la_f, rt_f, lt_f, va_f;

    // Shared multiplier
    logic signed [WW-1:0]                  mul_a;
    logic signed [vfdz_pkg::MUL_B_W-1:0]   mul_b;
    logic signed [vfdz_pkg::PROD_W-1:0]    mul_p, mul_q;

    function automatic logic signed [vfdz_pkg::MUL_B_W-1:0] frac_op(input logic [FW-1:0] f);
        return $signed({1'b0, f});
    endfunction

    // Limit of an edge: world minus view, kept in [0, POS_MAX]
    function automatic logic signed [WW-1:0] edge_limit(input logic [SW-1:0] world,
                                                       input logic [SW-1:0] view);
        logic signed [WW-1:0] diff;
        diff = $signed(WW'(world)) - $signed(WW'(view));
        if (diff < 0)
            return '0;
        else if (diff > $signed(WW'(vfdz_pkg::POS_MAX)))
            return $signed(WW'(vfdz_pkg::POS_MAX));
        else
            return diff;
    endfunction

    function automatic logic [PW-1:0] clamp_edge(input logic signed [WW-1:0] v,
                                                 input logic signed [WW-1:0] lim);
        if (v < 0)
            return '0;
        else if (v > lim)
            return lim[PW-1:0];
        else
            return v[PW-1:0];
    endfunction

    assign s_tready  = !busy_reg;
    assign in_accept = s_tvalid && s_tready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = vfdz_pkg::OUT_DATA_W'(out_data_reg);
    assign out_full  = out_valid_reg && !m_tready;

    assign cw = vfdz_pkg::prog_rom(pc_reg);

    assign txw     = WW'(tx_reg);
    assign tyw     = WW'(ty_reg);
    assign vww     = $signed(WW'(view_size_reg[SW-1:0]));
    assign vhw     = $signed(WW'(view_size_reg[2*SW-1:SW]));
    assign vw_half = $signed(WW'(view_size_reg[SW-1:1]));
    assign vh_half = $signed(WW'(view_size_reg[2*SW-1:SW+1]));
    assign vlw     = $signed(WW'(view_left_reg));
    assign vtw     = $signed(WW'(view_top_reg));
    assign upw     = $signed(WW'(dead_zones_reg[SW-1:0]));
    assign downw   = $signed(WW'(dead_zones_reg[2*SW-1:SW]));

    assign lim_x = edge_limit(world_size_reg[SW-1:0], view_size_reg[SW-1:0]);
    assign lim_y = edge_limit(world_size_reg[2*SW-1:SW], view_size_reg[2*SW-1:SW]);

    assign rate_f = vfdz_pkg::frac_sat(follow_rate_reg);
    assign ra_f   = vfdz_pkg::frac_sat(h_anchors_reg[FW-1:0]);
    assign la_f   = vfdz_pkg::frac_sat(h_anchors_reg[2*FW-1:FW]);
    assign rt_f   = vfdz_pkg::frac_sat(h_triggers_reg[FW-1:0]);
    assign lt_f   = vfdz_pkg::frac_sat(h_triggers_reg[2*FW-1:FW]);
    assign va_f   = vfdz_pkg::frac_sat(v_anchor_reg);

    assign rel      = txw - vlw;
    assign off_full = txw - (wx_reg + vw_half);
    assign base_y   = vtw + prod_reg;
    assign top_lim  = base_y - upw;
    assign bot_lim  = base_y + downw;

    // Product floored by the fraction width (arithmetic shift rounds toward minus infinity)
    assign mul_p = mul_a * mul_b;
    assign mul_q = mul_p >>> vfdz_pkg::RATIO_FRAC_BITS;

    // Condition select
    always_comb
    begin
        case (cw.cond)
            vfdz_pkg::COND_ALWAYS:   jump = 1'b1;
            vfdz_pkg::COND_CENTERED: jump = !type_reg;
            vfdz_pkg::COND_RELEASED: jump = (dir_reg == vfdz_pkg::DIR_NONE);
            vfdz_pkg::COND_OUT_FULL: jump = out_full;
            default:                 jump = 1'b0;
        endcase
    end

    // Datapath driven by the current control word
    always_comb
    begin
        view_left_next = view_left_reg;
        view_top_next  = view_top_reg;
        dir_next       = dir_reg;
        busy_next      = busy_reg;
        pc_next        = pc_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        wx_next        = wx_reg;
        wy_next        = wy_reg;
        d_next         = d_reg;
        prod_next      = prod_reg;
        off_next       = off_reg;
        mul_a          = vww;
        mul_b          = '0;

        if (busy_reg)
        begin
            pc_next = jump ? cw.target : pc_reg + 1'b1;

            unique case (cw.op)
                vfdz_pkg::OP_RELEASE:
                begin
                    if (md_reg != vfdz_pkg::DIR_NONE && dir_reg != vfdz_pkg::DIR_NONE
                        && md_reg != dir_reg)
                        dir_next = vfdz_pkg::DIR_NONE;
                end
                vfdz_pkg::OP_MUL_RT:
                begin
                    mul_b     = frac_op(rt_f);
                    prod_next = mul_q[WW-1:0];
                    wx_next   = vlw;
                end
                vfdz_pkg::OP_ARM_R:
                begin
                    if (dir_reg == vfdz_pkg::DIR_NONE && md_reg == vfdz_pkg::DIR_RIGHT
                        && rel > prod_reg)
                        dir_next = vfdz_pkg::DIR_RIGHT;
                end
                vfdz_pkg::OP_MUL_LT:
                begin
                    mul_b     = frac_op(lt_f);
                    prod_next = mul_q[WW-1:0];
                end
                vfdz_pkg::OP_ARM_L:
                begin
                    if (dir_reg == vfdz_pkg::DIR_NONE && md_reg == vfdz_pkg::DIR_LEFT
                        && rel < prod_reg)
                        dir_next = vfdz_pkg::DIR_LEFT;
                end
                vfdz_pkg::OP_MUL_ANCHOR:
                begin
                    mul_b     = (dir_reg == vfdz_pkg::DIR_RIGHT) ?
                                frac_op(ra_f) : frac_op(la_f);
                    prod_next = mul_q[WW-1:0];
                end
                vfdz_pkg::OP_DIFF:
                begin
                    d_next = txw - prod_reg - wx_reg;
                end
                vfdz_pkg::OP_MUL_RATE:
                begin
                    mul_a     = d_reg;
                    mul_b     = frac_op(rate_f);
                    prod_next = mul_q[WW-1:0];
                end
                vfdz_pkg::OP_ADD_X:
                begin
                    wx_next = wx_reg + prod_reg;
                end
                vfdz_pkg::OP_OFFSET:
                begin
                    mul_a     = vhw;
                    mul_b     = frac_op(va_f);
                    prod_next = mul_q[WW-1:0];
                    // saturate to the offset field
                    if (!off_full[WW-1] && (|off_full[WW-1:OW-1]))
                        off_next = {1'b0, {(OW-1){1'b1}}};
                    else if (off_full[WW-1] && !(&off_full[WW-1:OW-1]))
                        off_next = {1'b1, {(OW-1){1'b0}}};
                    else
                        off_next = off_full[OW-1:0];
                end
                vfdz_pkg::OP_DEAD_ZONE:
                begin
                    if (tyw < top_lim)
                        wy_next = tyw - prod_reg + upw;
                    else if (tyw > bot_lim)
                        wy_next = tyw - prod_reg - downw;
                    else
                        wy_next = vtw;
                end
                vfdz_pkg::OP_CLAMP:
                begin
                    view_left_next = clamp_edge(wx_reg, lim_x);
                    view_top_next  = clamp_edge(wy_reg, lim_y);
                end
                vfdz_pkg::OP_DONE:
                begin
                    if (!out_full)
                    begin
                        out_valid_next = 1'b1;
                        out_data_next  = {off_reg, dir_reg, view_top_reg, view_left_reg};
                        busy_next      = 1'b0;
                    end
                end
                vfdz_pkg::OP_CENTER:
                begin
                    wx_next  = txw - vw_half;
                    wy_next  = tyw - vh_half;
                    dir_next = vfdz_pkg::DIR_NONE;
                    off_next = '0;
                end
                default:
                begin
                    busy_next = 1'b0;
                end
            endcase
        end
        else if (in_accept)
        begin
            busy_next = 1'b1;
            pc_next   = '0;
        end
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg        <= 1'b0;
            pc_reg          <= '0;
            out_valid_reg   <= 1'b0;
            view_left_reg   <= '0;
            view_top_reg    <= '0;
            dir_reg         <= vfdz_pkg::DIR_NONE;
            view_size_reg   <= '0;
            world_size_reg  <= '0;
            follow_rate_reg <= vfdz_pkg::ONE_FRAC;
            h_anchors_reg   <= '0;
            h_triggers_reg  <= '0;
            v_anchor_reg    <= vfdz_pkg::HALF_FRAC;
            dead_zones_reg  <= '0;
        end
        else
        begin
            busy_reg      <= busy_next;
            pc_reg        <= pc_next;
            out_valid_reg <= out_valid_next;
            view_left_reg <= view_left_next;
            view_top_reg  <= view_top_next;
            dir_reg       <= dir_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    vfdz_pkg::CFG_VIEW_SIZE:   view_size_reg   <= cfg_data[2*SW-1:0];
                    vfdz_pkg::CFG_WORLD_SIZE:  world_size_reg  <= cfg_data[2*SW-1:0];
                    vfdz_pkg::CFG_FOLLOW_RATE: follow_rate_reg <= cfg_data[FW-1:0];
                    vfdz_pkg::CFG_H_ANCHORS:   h_anchors_reg   <= cfg_data[2*FW-1:0];
                    vfdz_pkg::CFG_H_TRIGGERS:  h_triggers_reg  <= cfg_data[2*FW-1:0];
                    vfdz_pkg::CFG_V_ANCHOR:    v_anchor_reg    <= cfg_data[FW-1:0];
                    vfdz_pkg::CFG_DEAD_ZONES:  dead_zones_reg  <= cfg_data[2*SW-1:0];
                    default:                   ;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            type_reg <= s_tuser;
            tx_reg   <= $signed(s_tdata[CW-1:0]);
            ty_reg   <= $signed(s_tdata[2*CW-1:CW]);
            // the pattern -2 counts as left
            md_reg   <= (s_tdata[2*CW+DW-1:2*CW] == vfdz_pkg::DIR_NEG2) ?
                        vfdz_pkg::DIR_LEFT : s_tdata[2*CW+DW-1:2*CW];
        end
        wx_reg       <= wx_next;
        wy_reg       <= wy_next;
        d_reg        <= d_next;
        prod_reg     <= prod_next;
        off_reg      <= off_next;
        out_data_reg <= out_data_next;
    end

endmodule

// ===== rtl/vfdz_checker.sv =====
// Port-level assertions for viewport_follow_dead_zone_unit, attached by bind.
// Depends on vfdz_pkg for the payload widths.
module vfdz_checker
(
    input logic                               clk,
    input logic                               rst_n,
    input logic                               s_tvalid,
    input logic                               s_tready,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [vfdz_pkg::OUT_DATA_W-1:0]    m_tdata
);

    localparam int DIR_LO = 2 * vfdz_pkg::POS_W;

    // one update in flight: input closes after a transaction
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input ready right after a transaction");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result changed while stalled");

    // follow direction is never the unused code
    a_dir_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[DIR_LO+vfdz_pkg::DIR_W-1:DIR_LO] != vfdz_pkg::DIR_NEG2))
        else $error("bad follow direction code");

    // a fresh result needs the block to have been working on an update
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        (!m_tvalid && s_tready) |=> !m_tvalid)
        else $error("result appeared without an update in flight");

endmodule

bind viewport_follow_dead_zone_unit vfdz_checker u_vfdz_checker (.*);
